// File: rtl/gated_track_fusion_table_defines.svh
// Assertion macros shared by the track table.
`ifndef GATED_TRACK_FUSION_TABLE_DEFINES_SVH
`define GATED_TRACK_FUSION_TABLE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define GTFT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define GTFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gtft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gtft_pkg;

  localparam int MaxResults = 16;

  localparam logic [1:0] ModeStart  = 2'd0;
  localparam logic [1:0] ModeDetect = 2'd1;
  localparam logic [1:0] ModeEnd    = 2'd2;

  localparam logic CfgGate = 1'b0;
  localparam logic CfgAge  = 1'b1;

  localparam logic [15:0] GateReset = 16'd600;
  localparam logic [7:0]  AgeReset  = 8'd60;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] det_x;
    logic signed [23:0] det_y;
    logic signed [23:0] det_z;
    logic signed [15:0] radial_velocity;
  } in_item_t;

  typedef struct packed {
    logic               valid_res;
    logic [15:0]        track_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [15:0]        danger_speed;
    logic [7:0]         sensor_hits;
    logic [7:0]         frames_idle;
    logic               created;
    logic               dropped;
    logic               last;
  } out_item_t;

  // One stored track.
  typedef struct packed {
    logic               valid;
    logic [15:0]        id;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]        danger;
    logic [7:0]         hits;
    logic [7:0]         age;
  } track_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic               age_step;
    logic               compare;
    logic               apply;
    logic               append;
    logic               shift;
    logic [15:0]        id;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]        mag;
    logic [33:0]        gate2;
    logic [7:0]         max_age;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: rtl/gated_track_fusion_table.sv
// Gated track fusion table.
// Input channel in_valid/in_stall/in_item carries frame-start, detection and
// frame-end beats; out_valid/out_stall/out_item carries results. The config
// port writes gate_distance (index 0) and max_age (index 1); the user writes
// only while idle, and the block does not enforce it. A frame start ages all
// tracks as taken, with no result; the next beat can follow in the next cycle.
// A detection registers the squared distance in every cell, then compares it
// against the gate and updates the first hit or appends a new track, and
// loads its result beat in the EMIT state after the update. A dropped
// detection, with the table full, loads its beat in the APPLY state.
// A frame end compacts the chain in SHIFT, one hole closed per cycle, then
// loads, while out_stall allows, one beat per cycle per surviving track
// (at most 16) from slot 0 onward, the last with last set.
// The output register holds its beat while out_stall is high. A new input is
// taken once the block is idle and the pending beat leaves. With an empty
// table a frame end gives a single empty beat with last set.
// Reset empties the table, sets the next id to one and loads the register
// defaults; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module gated_track_fusion_table #(
  parameter int TRACK_SLOTS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire gtft_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output gtft_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import gtft_pkg::*;
`include "gated_track_fusion_table_defines.svh"

  localparam int IdxW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int CntW = $clog2(TRACK_SLOTS + 1);

  typedef enum logic [2:0] {
    IDLE, CMP, APPLY, EMIT, SHIFT, READ
  } state_t;

  function automatic out_item_t track_beat(track_t t, logic made_f, logic lst);
    out_item_t r;
    r = '{1'b1, t.id, t.x, t.y, t.z, t.danger, t.hits, t.age, made_f, 1'b0, lst};
    return r;
  endfunction

  state_t            state;
  in_item_t          item;
  logic [15:0]       gate_distance;
  logic [7:0]        max_age;
  logic [15:0]       next_id;
  logic [CntW-1:0]   cnt;
  logic [IdxW-1:0]   rd;
  logic [CntW-1:0]   sent;
  logic              made;
  cell_cmd_t         cmd;

  track_t            tracks [TRACK_SLOTS];
  logic [TRACK_SLOTS-1:0] hits, keeps, valids, hole;
  logic [TRACK_SLOTS:0]   hb;

  logic [15:0]       mag;
  logic              any_hit;
  logic [IdxW-1:0]   hit_idx, free_idx;
  logic              full;
  logic [CntW-1:0]   n_valid;
  logic [CntW-1:0]   sent_next;
  logic              read_last;
  logic              load;
  out_item_t         beat;

  assign mag = item.radial_velocity[15] ? 16'(-item.radial_velocity)
                                        : 16'(item.radial_velocity);

  assign hb[0] = 1'b0;
  assign hole[0] = 1'b0;
  genvar g;
  generate
    for (g = 0; g < TRACK_SLOTS; g++) begin : g_cell
      track_t nxt;
      logic   prev_v;
      if (g == TRACK_SLOTS - 1) begin : g_end
        assign nxt = '0;
      end else begin : g_mid
        assign nxt = tracks[g+1];
        assign hole[g+1] = hole[g] | ~keeps[g];
      end
      if (g == 0) begin : g_first
        assign prev_v = 1'b1;
      end else begin : g_rest
        assign prev_v = valids[g-1];
      end
      gtft_cell u_cell (
        .clk(clk), .rst(rst), .cmd(cmd), .from_next(nxt),
        .hit_before(hb[g]), .hole_before(hole[g]), .prev_valid(prev_v),
        .track(tracks[g]), .hit(hits[g]), .keep(keeps[g])
      );
      assign hb[g+1] = hb[g] | hits[g];
      assign valids[g] = tracks[g].valid;
    end
  endgenerate

  always_comb begin
    any_hit = hb[TRACK_SLOTS];
    hit_idx = '0;
    free_idx = '0;
    n_valid = '0;
    for (int i = TRACK_SLOTS - 1; i >= 0; i--) begin
      if (hits[i]) hit_idx = IdxW'(i);
    end
    for (int i = 0; i < TRACK_SLOTS; i++) begin
      if (valids[i]) n_valid = n_valid + CntW'(1);
    end
    free_idx = IdxW'(n_valid);
    full = (n_valid == CntW'(TRACK_SLOTS));
  end

  always_comb begin
    cmd = '0;
    cmd.x = item.det_x;
    cmd.y = item.det_y;
    cmd.z = item.det_z;
    cmd.mag = mag;
    cmd.id = next_id;
    cmd.gate2 = 34'(gate_distance) * 34'(gate_distance);
    cmd.max_age = max_age;
    cmd.compare = (state == CMP);
    cmd.apply = (state == APPLY);
    cmd.append = (state == APPLY) && !any_hit;
    cmd.shift = (state == SHIFT);
    cmd.age_step = (state == IDLE) && in_valid && !in_stall &&
                   (in_item.mode == ModeStart);
  end

  assign in_stall = (state != IDLE) || (out_valid && out_stall);

  assign sent_next = sent + CntW'(1);
  assign read_last = (sent_next == n_valid) || (sent_next == CntW'(MaxResults));

  // Beat loaded into the output register this cycle, if any.
  always_comb begin
    load = 1'b0;
    beat = '0;
    case (state)
      APPLY: begin
        if (!any_hit && full) begin
          load = 1'b1;
          beat.dropped = 1'b1;
          beat.last = 1'b1;
        end
      end
      EMIT: begin
        load = 1'b1;
        beat = track_beat(tracks[rd], made, 1'b1);
      end
      READ: begin
        if (!out_valid || !out_stall) begin
          load = 1'b1;
          if (n_valid == '0) beat.last = 1'b1;
          else beat = track_beat(tracks[rd], 1'b0, read_last);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      gate_distance <= GateReset;
      max_age <= AgeReset;
      next_id <= 16'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgGate: gate_distance <= cfg_data;
          CfgAge:  max_age <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (load) begin
        out_item <= beat;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid && !in_stall) begin
            item <= in_item;
            if (in_item.mode == ModeDetect) state <= CMP;
            else if (in_item.mode == ModeEnd) begin
              state <= SHIFT;
              cnt <= '0;
            end
          end
        end
        CMP: state <= APPLY;
        APPLY: begin
          made <= !any_hit;
          if (any_hit) begin
            state <= EMIT;
            rd <= hit_idx;
          end else if (full) begin
            state <= IDLE;
          end else begin
            next_id <= next_id + 16'd1;
            rd <= free_idx;
            state <= EMIT;
          end
        end
        EMIT: state <= IDLE;
        SHIFT: begin
          cnt <= cnt + CntW'(1);
          if (cnt == CntW'(TRACK_SLOTS - 1)) begin
            state <= READ;
            rd <= '0;
            sent <= '0;
          end
        end
        READ: begin
          if (load) begin
            sent <= sent_next;
            rd <= rd + IdxW'(1);
            if ((n_valid == '0) || read_last) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `GTFT_ASSERT_IMPL(a_stall_busy, clk, rst, state != IDLE, in_stall,
    "input taken while busy")
  `GTFT_ASSERT_NEXT(a_prefix, clk, rst, state == READ && !out_stall,
    valids[0] || out_item.last, "empty table must give a single beat")
  `GTFT_ASSERT_IMPL(a_one_hit_first, clk, rst, state == APPLY && any_hit,
    hits[hit_idx], "first hit index lost")
  `GTFT_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_item), "stalled beat changed")
endmodule
`default_nettype wire

// File: rtl/gtft_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One slot of the table. A compare cycle registers the squared distance; an
// apply cycle checks it against the gate and updates the slot if it is the
// first hit in the chain, or fills the first free slot when nothing hit.
// A shift cycle pulls the neighbor's track in for every slot at or after the
// first slot that holds no survivor.
module gtft_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gtft_pkg::cell_cmd_t  cmd,
  input  wire gtft_pkg::track_t     from_next,
  input  wire logic                 hit_before,
  input  wire logic                 hole_before,
  input  wire logic                 prev_valid,
  output gtft_pkg::track_t          track,
  output logic                      hit,
  output logic                      keep
);
  import gtft_pkg::*;

  logic signed [24:0] dx, dy, dz;
  logic        [47:0] sx, sy, sz;
  logic        [49:0] d2, d2_r;
  logic        [15:0] id;
  logic signed [23:0] x, y, z;
  logic        [15:0] danger;
  logic        [7:0]  hits, age;
  logic               valid;

  assign track = '{valid, id, x, y, z, danger, hits, age};

  always_comb begin
    dx = 25'(x) - 25'(cmd.x);
    dy = 25'(y) - 25'(cmd.y);
    dz = 25'(z) - 25'(cmd.z);
    sx = 48'(dx * dx);
    sy = 48'(dy * dy);
    sz = 48'(dz * dz);
    d2 = 50'(sx) + 50'(sy) + 50'(sz);
  end

  assign hit  = valid && (d2_r < 50'(cmd.gate2));
  assign keep = valid && (age <= cmd.max_age);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (cmd.compare) d2_r <= d2;
      if (cmd.age_step) begin
        if (valid) begin
          if (age != 8'hFF) age <= age + 8'd1;
          hits <= 8'd0;
        end
      end else if (cmd.apply && hit && !hit_before) begin
        x <= cmd.x;
        y <= cmd.y;
        z <= cmd.z;
        if (cmd.mag > danger) danger <= cmd.mag;
        if (hits != 8'hFF) hits <= hits + 8'd1;
        age <= 8'd0;
      end else if (cmd.append && !valid && prev_valid) begin
        valid  <= 1'b1;
        id     <= cmd.id;
        x      <= cmd.x;
        y      <= cmd.y;
        z      <= cmd.z;
        danger <= cmd.mag;
        hits   <= 8'd1;
        age    <= 8'd0;
      end else if (cmd.shift && (!keep || hole_before)) begin
        valid  <= from_next.valid;
        id     <= from_next.id;
        x      <= from_next.x;
        y      <= from_next.y;
        z      <= from_next.z;
        danger <= from_next.danger;
        hits   <= from_next.hits;
        age    <= from_next.age;
      end
    end
  end
endmodule
`default_nettype wire

// File: verif/track_table_checker.sv
`timescale 1ns / 1ps
module track_table_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gtft_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gtft_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  errors,
  output int                  pending
);
  import gtft_pkg::*;

  localparam int Slots = 16;

  track_t    tracks[Slots];
  logic [15:0] id_next;
  logic [15:0] gate_r;
  logic [7:0]  age_limit;
  out_item_t expected_beats[$];

  function automatic out_item_t track_beat(track_t t, logic made);
    out_item_t r;
    r = '0;
    r.valid_res = 1'b1;
    r.track_id = t.id;
    r.pos_x = t.x;
    r.pos_y = t.y;
    r.pos_z = t.z;
    r.danger_speed = t.danger;
    r.sensor_hits = t.hits;
    r.frames_idle = t.age;
    r.created = made;
    return r;
  endfunction

  function automatic longint sq(logic signed [23:0] a, logic signed [23:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  task automatic fuse_item(in_item_t it);
    out_item_t r;
    longint gate2;
    logic [15:0] mag;
    int keep;
    int n;
    bit done;
    done = 0;
    r = '0;
    case (it.mode)
      ModeStart: begin
        for (int s = 0; s < Slots; s++) begin
          if (tracks[s].valid) begin
            if (tracks[s].age != 8'hff) tracks[s].age++;
            tracks[s].hits = '0;
          end
        end
      end
      ModeDetect: begin
        gate2 = longint'(gate_r) * longint'(gate_r);
        mag = it.radial_velocity[15] ? 16'(-it.radial_velocity) : it.radial_velocity;
        for (int s = 0; s < Slots && !done; s++) begin
          if (tracks[s].valid && sq(tracks[s].x, it.det_x) + sq(tracks[s].y, it.det_y)
              + sq(tracks[s].z, it.det_z) < gate2) begin
            tracks[s].x = it.det_x;
            tracks[s].y = it.det_y;
            tracks[s].z = it.det_z;
            if (mag > tracks[s].danger) tracks[s].danger = mag;
            if (tracks[s].hits != 8'hff) tracks[s].hits++;
            tracks[s].age = '0;
            r = track_beat(tracks[s], 1'b0);
            done = 1;
          end
        end
        for (int s = 0; s < Slots && !done; s++) begin
          if (!tracks[s].valid) begin
            tracks[s] = '{valid: 1'b1, id: id_next, x: it.det_x, y: it.det_y,
                          z: it.det_z, danger: mag, hits: 8'd1, age: 8'd0};
            id_next++;
            r = track_beat(tracks[s], 1'b1);
            done = 1;
          end
        end
        if (!done) r.dropped = 1'b1;
        r.last = 1'b1;
        expected_beats = {expected_beats, r};
      end
      ModeEnd: begin
        keep = 0;
        for (int s = 0; s < Slots; s++) begin
          if (tracks[s].valid && tracks[s].age <= age_limit) begin
            tracks[keep] = tracks[s];
            keep++;
          end
        end
        for (int s = keep; s < Slots; s++) tracks[s].valid = 1'b0;
        n = (keep > MaxResults) ? MaxResults : keep;
        for (int s = 0; s < n; s++) begin
          r = track_beat(tracks[s], 1'b0);
          r.last = (s == n - 1);
          expected_beats = {expected_beats, r};
        end
        if (n == 0) begin
          r = '0;
          r.last = 1'b1;
          expected_beats = {expected_beats, r};
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      for (int s = 0; s < Slots; s++) tracks[s] = '0;
      id_next = 16'd1;
      gate_r = GateReset;
      age_limit = AgeReset;
      expected_beats.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgGate) gate_r = cfg_data;
        else age_limit = cfg_data[7:0];
      end
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %h", $time, out_item);
        end else begin
          e = expected_beats.pop_front();
          if (e !== out_item) begin
            errors++;
            $display("%0t: mismatch expected %h actual %h", $time, e, out_item);
          end
        end
      end
      if (in_valid && !in_stall) fuse_item(in_item);
    end
    pending = expected_beats.size();
  end
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import gtft_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int errors;
  int pending;
  bit quiet_tail = 0;
  bit hold_off = 0;

  gated_track_fusion_table dut (.*);
  track_table_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver stall in random bursts, plus one long hold-off.
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Valid stays high after the beat is taken until the next beat or an idle
  // burst replaces it, so each edge sees at most one update of in_valid.
  task automatic send(in_item_t it);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic in_item_t make(logic [1:0] m, int x, int y, int z, int v);
    in_item_t it;
    it.mode = m;
    it.det_x = 24'(x);
    it.det_y = 24'(y);
    it.det_z = 24'(z);
    it.radial_velocity = 16'(v);
    return it;
  endfunction

  function automatic int near(int c, int spread);
    return c + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic set_reg(logic idx, logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int items, int spread);
    int cx[4];
    int r;
    for (int i = 0; i < 4; i++) cx[i] = $signed($urandom) >>> 8;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send(make(ModeStart, 0, 0, 0, 0));
      else if (r == 1) send(make(ModeEnd, 0, 0, 0, 0));
      else if (r == 2) send(make(2'd3, $urandom, $urandom, $urandom, $urandom));
      else if (r < 6)
        send(make(ModeDetect, $urandom, $urandom, $urandom, $urandom));
      else
        send(make(ModeDetect, near(cx[r % 4], spread), near(cx[(r + 1) % 4], spread),
                  near(cx[(r + 2) % 4], spread), $urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, a near miss of the gate, append, ageing, unused mode, full table.
    send(make(ModeEnd, 0, 0, 0, 0));
    send(make(ModeDetect, -8388608, 8388607, -8388608, -32768));
    send(make(ModeDetect, -8388000, 8388607, -8388608, 32767));
    send(make(ModeDetect, 8388607, -8388608, 8388607, 5));
    send(make(ModeStart, 0, 0, 0, 0));
    send(make(2'd3, -1, -1, -1, -1));
    send(make(ModeEnd, 0, 0, 0, 0));
    for (int i = 0; i < 16; i++) send(make(ModeDetect, i * 5000, 0, 0, i));
    send(make(ModeEnd, 0, 0, 0, 0));
    set_reg(CfgAge, 16'd0);
    send(make(ModeStart, 0, 0, 0, 0));
    send(make(ModeEnd, 0, 0, 0, 0));
    // Gate of zero never matches; max gate matches only closer than 65535.
    set_reg(CfgGate, 16'd0);
    set_reg(CfgAge, 16'd255);
    hold_off = 1;
    random_phase(60, 3);
    set_reg(CfgGate, 16'hffff);
    random_phase(60, 1000000);
    set_reg(CfgGate, 16'd600);
    set_reg(CfgAge, 16'd3);
    random_phase(80, 400);
    set_reg(CfgAge, 16'd60);
    quiet_tail = 1;
    random_phase(100, 300);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
